// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the RTL.
// ----------------------------------------------------------------------------
// ASSERT_HOLDS checks an expression at every clock edge outside reset.
// ASSERT_NEXT checks that an antecedent implies a consequent in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/dks_pkg.sv =====
// ----------------------------------------------------------------------------
// dks_pkg
// Types, permutation tables and helper functions for the DES key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

package dks_pkg;

  localparam int KEY_W    = 64;
  localparam int HALF_W   = 28;
  localparam int CD_W     = 56;
  localparam int SUBKEY_W = 48;
  localparam int ROUNDS   = 16;
  localparam int ROUND_W  = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key_word;
    logic             key_slot;
  } in_t;

  typedef struct packed {
    logic [SUBKEY_W-1:0] subkey;
    logic [ROUND_W-1:0]  round_index;
    logic                slot_out;
    logic                last;
  } out_t;

  // One cell of the chain: the rotated C||D word for that cell's round.
  typedef struct packed {
    logic            valid;
    logic            slot;
    logic [CD_W-1:0] cd;
  } cell_t;

  localparam logic [6:0] PC1_SEL [CD_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
    7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
    7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
    7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
    7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [6:0] PC2_SEL [SUBKEY_W] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,
    7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,
    7'd27, 7'd20, 7'd13, 7'd2,  7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
    7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
    7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  // Bit r is set where round r rotates both halves by two places, else by one.
  localparam logic [ROUNDS-1:0] ROT_TWO = 16'h7EFC;

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] r;
    for (int i = 0; i < CD_W; i++) begin
      r[i] = key[6'(PC1_SEL[i] - 7'd1)];
    end
    return r;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] r;
    for (int i = 0; i < SUBKEY_W; i++) begin
      r[i] = cd[6'(PC2_SEL[i] - 7'd1)];
    end
    return r;
  endfunction

  // Both halves move toward bit 0; bits leaving the bottom wrap to bit 27.
  function automatic logic [CD_W-1:0] rot_cd(input logic [CD_W-1:0] cd,
                                             input logic two);
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
    c = cd[HALF_W-1:0];
    d = cd[CD_W-1:HALF_W];
    if (two) begin
      c = {c[1:0], c[HALF_W-1:2]};
      d = {d[1:0], d[HALF_W-1:2]};
    end else begin
      c = {c[0], c[HALF_W-1:1]};
      d = {d[0], d[HALF_W-1:1]};
    end
    return {d, c};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dks_cell.sv =====
// ----------------------------------------------------------------------------
// dks_cell
// One round cell: takes the key state from its left neighbor and rotates it.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_cell
  import dks_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [ROUND_W-1:0] round_no,
  input  cell_t              prev,
  output cell_t              cur
);

  logic            valid;
  logic            slot;
  logic [CD_W-1:0] cd;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot <= prev.slot;
      cd   <= rot_cd(prev.cd, ROT_TWO[round_no]);
    end
  end

  assign cur = '{valid: valid, slot: slot, cd: cd};

endmodule

`default_nettype wire

// ===== rtl/dks_emit.sv =====
// ----------------------------------------------------------------------------
// dks_emit
// Output register: picks the active cell, applies PC-2 and holds the request.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_emit
  import dks_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cell_t cells [ROUNDS],
  input  logic  out_ready,
  output logic  advance,
  output logic  out_valid,
  output out_t  out_data
);

  logic               any_valid;
  logic               sel_slot;
  logic [CD_W-1:0]    sel_cd;
  logic [ROUND_W-1:0] sel_round;

  // At most one cell holds a key, so an OR across the row selects it.
  always_comb begin
    any_valid = 1'b0;
    sel_slot  = 1'b0;
    sel_cd    = '0;
    sel_round = '0;
    for (int k = 0; k < ROUNDS; k++) begin
      if (cells[k].valid) begin
        any_valid = 1'b1;
        sel_slot  = sel_slot | cells[k].slot;
        sel_cd    = sel_cd | cells[k].cd;
        sel_round = sel_round | ROUND_W'(k);
      end
    end
  end

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= any_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.subkey      <= pc2(sel_cd);
      out_data.round_index <= sel_round;
      out_data.slot_out    <= sel_slot;
      out_data.last        <= cells[ROUNDS-1].valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/des_key_schedule.sv =====
// ----------------------------------------------------------------------------
// des_key_schedule
// DES round key generator built as a row of sixteen round cells.
// ----------------------------------------------------------------------------
// Usage: a request on in_data carries a 64-bit key and a slot bit. The block
// answers with sixteen requests on out_data, one per round, each with the
// 48-bit subkey, its round number, the slot bit and a last flag on round 15.
// An accepted key is registered in cell 0 and then in the output register as
// the round 0 subkey; the rest follow one per cycle while out_ready is high.
// One output channel carries one subkey per cycle, so a new key waits while
// the key ahead is in cells 0 to 14. The next key is accepted in the same
// cycle round 15 moves into the output register; runs follow without a gap.
// A key moves one cell per cycle unless the row holds; each cell applies
// its round's rotation, and the output register applies PC-2.
// While out_valid is high and out_ready is low, the output register and the
// whole row hold, and in_ready drops. Reset empties the row and the output
// register; the block is ready for a key in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module des_key_schedule
  import dks_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cell_t              head;
  cell_t              cells [ROUNDS];
  logic               advance;
  logic [ROUNDS-1:0]  cell_valid;

  // A new key may enter only when the row is empty or its key is leaving.
  assign in_ready = advance && (cell_valid[ROUNDS-2:0] == '0);

  assign head = '{valid: in_valid && in_ready,
                  slot:  in_data.key_slot,
                  cd:    pc1(in_data.key_word)};

  for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
    if (k == 0) begin : g_first
      dks_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .advance  (advance),
        .round_no (ROUND_W'(k)),
        .prev     (head),
        .cur      (cells[k])
      );
    end else begin : g_rest
      dks_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .advance  (advance),
        .round_no (ROUND_W'(k)),
        .prev     (cells[k-1]),
        .cur      (cells[k])
      );
    end
    assign cell_valid[k] = cells[k].valid;
  end

  dks_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cells     (cells),
    .out_ready (out_ready),
    .advance   (advance),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `ASSERT_HOLDS(a_one_key_in_row, clk, rst, $onehot0(cell_valid))
  `ASSERT_NEXT(a_accept_loads_first, clk, rst, in_valid && in_ready, cell_valid[0])
  `ASSERT_NEXT(a_stall_holds_row, clk, rst, out_valid && !out_ready, $stable(cell_valid))

endmodule

`default_nettype wire
